// ===== sv/bfrs_pkg.sv =====
// Shared types and constants for the box-filtered running statistics block.
// No dependencies.
`default_nettype none
package bfrs_pkg;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 32;
    localparam int FRAC_W  = 16;
    localparam int MEAN_W  = 48;
    localparam int MAG_W   = 48;
    localparam int PROD_W  = 2 * MAG_W;
    localparam int SQ_W    = PROD_W - FRAC_W;
    localparam int SUM_W   = 64;
    localparam int DEV_W   = 64;
    localparam int NREG    = 6;
    localparam int DATA_W  = 336;

    localparam logic [COUNT_W-1:0] COUNT_LIMIT = '1;
    localparam logic [TIME_W-1:0]  TIME_MAX_V  = {1'b0, {(TIME_W-1){1'b1}}};
    localparam logic [TIME_W-1:0]  TIME_MIN_V  = {1'b1, {(TIME_W-1){1'b0}}};

    localparam logic [1:0] DSEL_SQ   = 2'd0;
    localparam logic [1:0] DSEL_MEAN = 2'd1;
    localparam logic [1:0] DSEL_VAR  = 2'd2;

    typedef logic signed [31:0] box_t [NREG];

    typedef struct packed {
        logic       cap;
        logic       upd;
        logic       mul_start;
        logic       div_start;
        logic [1:0] div_sel;
        logic       apply_sq;
        logic       apply_mean;
        logic       apply_var;
        logic       load_out;
    } cmd_t;

    typedef struct packed {
        logic hit;
        logic first;
        logic mul_done;
        logic div_done;
        logic out_busy;
    } stat_t;
endpackage
`default_nettype wire

// ===== sv/bfrs_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on bfrs_pkg.
`default_nettype none
module bfrs_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [bfrs_pkg::SQ_W-1:0]   dividend,
    input  wire logic [bfrs_pkg::COUNT_W-1:0] divisor,
    output logic                             done,
    output logic [bfrs_pkg::SQ_W-1:0]        quotient,
    output logic                             rem_nz
);
    localparam int CW = $clog2(bfrs_pkg::SQ_W + 1);

    logic [bfrs_pkg::COUNT_W:0]   rem_reg, rem_next, rem_sh;
    logic [bfrs_pkg::SQ_W-1:0]    quo_reg, quo_next;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic                         busy_reg, busy_next, done_reg, done_next;
    logic                         qbit;

    always_comb begin
        rem_sh    = {rem_reg[bfrs_pkg::COUNT_W-1:0], quo_reg[bfrs_pkg::SQ_W-1]};
        qbit      = rem_sh >= {1'b0, divisor};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CW'(bfrs_pkg::SQ_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = qbit ? rem_sh - {1'b0, divisor} : rem_sh;
            quo_next = {quo_reg[bfrs_pkg::SQ_W-2:0], qbit};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
    assign rem_nz   = rem_reg != '0;
endmodule
`default_nettype wire

// ===== sv/bfrs_dp.sv =====
// Datapath: statistics registers, shift-add squarer, shared divider, output word.
// Depends on bfrs_pkg and bfrs_div.
`default_nettype none
module bfrs_dp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire bfrs_pkg::cmd_t                cmd,
    output bfrs_pkg::stat_t                    stat,
    input  wire bfrs_pkg::box_t                box,
    input  wire logic [127:0]                  s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [bfrs_pkg::DATA_W-1:0]        m_tdata,
    output logic                               m_tuser
);
    localparam int MCW = $clog2(bfrs_pkg::MAG_W + 1);

    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic signed [bfrs_pkg::TIME_W-1:0] t_reg;
    logic [bfrs_pkg::COUNT_W-1:0] count_reg;
    logic [bfrs_pkg::SUM_W-1:0]   sum_reg;
    logic signed [bfrs_pkg::TIME_W-1:0] min_reg, max_reg;
    logic [bfrs_pkg::MEAN_W-1:0]  mean_reg;
    logic [bfrs_pkg::DEV_W-1:0]   sqdev_reg, var_reg;
    logic                         hit_reg;
    logic [bfrs_pkg::MAG_W-1:0]   mag_reg, mplier_reg;
    logic                         dneg_reg;
    logic [bfrs_pkg::PROD_W-1:0]  acc_reg, mcand_reg;
    logic [MCW-1:0]               mcnt_reg;
    logic                         mbusy_reg, mdone_reg;
    logic                         ov_reg;
    logic [bfrs_pkg::DATA_W-1:0]  od_reg;
    logic                         ou_reg;

    logic                         inbox;
    logic [bfrs_pkg::MEAN_W-1:0]  v48;
    logic [bfrs_pkg::MEAN_W:0]    d49, dabs;
    logic [bfrs_pkg::SQ_W-1:0]    sq, dvd, quo;
    logic                         div_done, rem_nz;
    logic [bfrs_pkg::SQ_W:0]      qc, inc;
    logic [bfrs_pkg::DEV_W:0]     dev_sum;

    assign inbox = px_reg >= box[0] && px_reg <= box[1] &&
                   py_reg >= box[2] && py_reg <= box[3] &&
                   pz_reg >= box[4] && pz_reg <= box[5];
    assign v48  = {t_reg, {bfrs_pkg::FRAC_W{1'b0}}};
    assign d49  = {v48[bfrs_pkg::MEAN_W-1], v48} - {mean_reg[bfrs_pkg::MEAN_W-1], mean_reg};
    assign dabs = d49[bfrs_pkg::MEAN_W] ? -d49 : d49;
    assign sq   = acc_reg[bfrs_pkg::PROD_W-1:bfrs_pkg::FRAC_W];
    assign qc   = {1'b0, quo} + (bfrs_pkg::SQ_W+1)'(rem_nz);
    assign inc  = {1'b0, sq} - qc;
    assign dev_sum = {1'b0, sqdev_reg} + {1'b0, inc[bfrs_pkg::DEV_W-1:0]};

    always_comb begin
        unique case (cmd.div_sel)
            bfrs_pkg::DSEL_SQ:   dvd = sq;
            bfrs_pkg::DSEL_MEAN: dvd = bfrs_pkg::SQ_W'(mag_reg);
            default:             dvd = bfrs_pkg::SQ_W'(sqdev_reg);
        endcase
    end

    bfrs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (dvd),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (quo),
        .rem_nz   (rem_nz)
    );

    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            px_reg <= s_tdata[31:0];
            py_reg <= s_tdata[63:32];
            pz_reg <= s_tdata[95:64];
            t_reg  <= s_tdata[96 +: bfrs_pkg::TIME_W];
        end
        if (cmd.upd) begin
            mag_reg  <= dabs[bfrs_pkg::MAG_W-1:0];
            dneg_reg <= d49[bfrs_pkg::MEAN_W];
        end
        if (cmd.mul_start) begin
            acc_reg    <= '0;
            mcand_reg  <= bfrs_pkg::PROD_W'(mag_reg);
            mplier_reg <= mag_reg;
            mcnt_reg   <= MCW'(bfrs_pkg::MAG_W);
        end else if (mbusy_reg) begin
            if (mplier_reg[0]) acc_reg <= acc_reg + mcand_reg;
            mcand_reg  <= mcand_reg << 1;
            mplier_reg <= mplier_reg >> 1;
            mcnt_reg   <= mcnt_reg - 1'b1;
        end
        if (cmd.load_out) begin
            od_reg <= {var_reg, sqdev_reg, mean_reg, max_reg, min_reg, sum_reg, count_reg};
            ou_reg <= hit_reg;
        end
        if (!aresetn) begin
            count_reg <= '0;
            sum_reg   <= '0;
            min_reg   <= bfrs_pkg::TIME_MAX_V;
            max_reg   <= bfrs_pkg::TIME_MIN_V;
            mean_reg  <= '0;
            sqdev_reg <= '0;
            var_reg   <= '0;
            hit_reg   <= 1'b0;
            mbusy_reg <= 1'b0;
            mdone_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end else begin
            mdone_reg <= 1'b0;
            if (cmd.mul_start) begin
                mbusy_reg <= 1'b1;
            end else if (mbusy_reg && mcnt_reg == MCW'(1)) begin
                mbusy_reg <= 1'b0;
                mdone_reg <= 1'b1;
            end
            if (cmd.cap) hit_reg <= 1'b0;
            if (cmd.upd) begin
                hit_reg   <= 1'b1;
                count_reg <= count_reg + 1'b1;
                sum_reg   <= sum_reg + bfrs_pkg::SUM_W'(t_reg);
                if (t_reg < min_reg) min_reg <= t_reg;
                if (t_reg > max_reg) max_reg <= t_reg;
                if (count_reg == '0) begin
                    mean_reg  <= v48;
                    sqdev_reg <= '0;
                    var_reg   <= '0;
                end
            end
            if (cmd.apply_sq) begin
                if (inc[bfrs_pkg::SQ_W:bfrs_pkg::DEV_W] != '0 || dev_sum[bfrs_pkg::DEV_W])
                    sqdev_reg <= '1;
                else
                    sqdev_reg <= dev_sum[bfrs_pkg::DEV_W-1:0];
            end
            if (cmd.apply_mean) begin
                mean_reg <= dneg_reg ? mean_reg - quo[bfrs_pkg::MEAN_W-1:0]
                                     : mean_reg + quo[bfrs_pkg::MEAN_W-1:0];
            end
            if (cmd.apply_var) var_reg <= quo[bfrs_pkg::DEV_W-1:0];
            if (cmd.load_out) ov_reg <= 1'b1;
            else if (m_tready) ov_reg <= 1'b0;
        end
    end

    assign stat.hit      = inbox && count_reg != bfrs_pkg::COUNT_LIMIT;
    assign stat.first    = count_reg == bfrs_pkg::COUNT_W'(1);
    assign stat.mul_done = mdone_reg;
    assign stat.div_done = div_done;
    assign stat.out_busy = ov_reg && !m_tready;
    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;
    assign m_tuser  = ou_reg;
endmodule
`default_nettype wire

// ===== sv/bfrs_ctrl.sv =====
// Sequencing state machine for one sample at a time.
// Depends on bfrs_pkg.
`default_nettype none
module bfrs_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire bfrs_pkg::stat_t stat,
    output bfrs_pkg::cmd_t       cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_TEST = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DSQ  = 3'd4;
    localparam logic [2:0] S_DMN  = 3'd5;
    localparam logic [2:0] S_DVR  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.cap    = 1'b1;
                    state_next = S_TEST;
                end
            end
            S_TEST: begin
                cmd.upd    = stat.hit;
                state_next = stat.hit ? S_CHK : S_OUT;
            end
            S_CHK: begin
                if (stat.first) begin
                    state_next = S_OUT;
                end else begin
                    cmd.mul_start = 1'b1;
                    state_next    = S_MUL;
                end
            end
            S_MUL: begin
                if (stat.mul_done) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = bfrs_pkg::DSEL_SQ;
                    state_next    = S_DSQ;
                end
            end
            S_DSQ: begin
                if (stat.div_done) begin
                    cmd.apply_sq  = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = bfrs_pkg::DSEL_MEAN;
                    state_next    = S_DMN;
                end
            end
            S_DMN: begin
                cmd.div_sel = bfrs_pkg::DSEL_VAR;
                if (stat.div_done) begin
                    cmd.apply_mean = 1'b1;
                    cmd.div_start  = 1'b1;
                    state_next     = S_DVR;
                end
            end
            S_DVR: begin
                if (stat.div_done) begin
                    cmd.apply_var = 1'b1;
                    state_next    = S_OUT;
                end
            end
            S_OUT: begin
                if (!stat.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end
endmodule
`default_nettype wire

// ===== sv/box_filtered_running_stats_top.sv =====
// Steps: a sample outside the box or at the count limit goes straight to the output word;
// the first counted sample also passes the count check; others run the shift-add squarer,
// then three divisions by the count on the shared divider; the output waits on m_tready.
// Throughput: one sample at a time; the next is taken in the cycle after the result loads.
// Reset: synchronous active-low aresetn empties the statistics and clears the box registers.
// Top level: APB register file, controller and datapath; needs bfrs_pkg, bfrs_ctrl, bfrs_dp.
`default_nettype none
module box_filtered_running_stats_top (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,  // pos_x, pos_y, pos_z, sample_time
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // match_count, time_sum, time_min, time_max, mean_fixed, sq_dev_sum, variance_fixed
    output logic [bfrs_pkg::DATA_W-1:0] m_tdata,
    output logic              m_tuser   // in_region
);
    bfrs_pkg::box_t  box_reg;
    bfrs_pkg::cmd_t  cmd;
    bfrs_pkg::stat_t stat;
    logic [2:0]      ridx;

    assign ridx   = paddr[4:2];
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < bfrs_pkg::NREG; i++) box_reg[i] <= '0;
        end else if (psel && penable && pwrite && ridx < 3'(bfrs_pkg::NREG)) begin
            box_reg[ridx] <= pwdata;
        end
    end

    always_comb begin
        prdata = '0;
        if (ridx < 3'(bfrs_pkg::NREG)) prdata = box_reg[ridx];
    end

    bfrs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bfrs_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .box      (box_reg),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );
endmodule
`default_nettype wire

// ===== sv/bfrs_checker.sv =====
// Port-level checks for the top level, attached by bind.
// Depends on box_filtered_running_stats_top ports.
`default_nettype none
module bfrs_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [335:0] m_tdata,
    input wire logic         m_tuser
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word dropped or changed while stalled");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a sample is in work");

    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[31:0] != 32'd0)
        else $error("counted sample with zero count");

    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[31:0] != 32'd0 |->
            $signed(m_tdata[127:96]) <= $signed(m_tdata[159:128]))
        else $error("time_min above time_max");

    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[31:0] == 32'd0 |-> m_tdata[335:208] == '0)
        else $error("deviation stats nonzero with no samples");
endmodule

bind box_filtered_running_stats_top bfrs_checker u_bfrs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

// ===== tb/sv/box_filtered_running_stats_top_test.sv =====
// Testbench for box_filtered_running_stats_top: box setup over APB, samples on the input
// stream, every result word checked against a built-in predictor of the running stats or a typed result.
// Depends on bfrs_pkg and box_filtered_running_stats_top.
`timescale 1ns / 100ps
module box_filtered_running_stats_top_test;
    localparam int REG_X_LO = 0, REG_X_HI = 1, REG_Y_LO = 2, REG_Y_HI = 3;
    localparam int REG_Z_LO = 4, REG_Z_HI = 5;
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_CYCLES = 600;

    typedef struct packed {
        logic               in_region;
        logic [31:0]        count;
        logic [63:0]        tsum;
        logic [31:0]        tmin;
        logic [31:0]        tmax;
        logic [47:0]        mean;
        logic [63:0]        sqdev;
        logic [63:0]        variance;
    } stats_t;

    typedef struct {
        logic signed [31:0] x, y, z, t;
        bit                 typed;
        stats_t             res;
    } row_t;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         psel = 0, penable = 0, pwrite = 0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [127:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [bfrs_pkg::DATA_W-1:0] m_tdata;
    logic         m_tuser;

    box_filtered_running_stats_top u_top (.*);

    always #4 aclk = ~aclk;

    // predictor state
    logic signed [31:0] box_q [bfrs_pkg::NREG];
    logic [31:0]        n_cnt;
    logic [63:0]        t_sum;
    logic signed [31:0] t_min, t_max;
    logic signed [47:0] mean_q;
    logic [63:0]        sqdev_q;

    stats_t stats_due [$];
    int     errors = 0, words_in = 0, words_out = 0, hits = 0, idle_cnt = 0;
    int     burst_left = 0, max_gap = 4;
    bit     hold_go = 0;

    function automatic logic signed [47:0] sat48(logic signed [63:0] v);
        if (v > 64'sh7FFF_FFFF_FFFF) return 48'sh7FFF_FFFF_FFFF;
        if (v < -64'sh8000_0000_0000) return 48'sh8000_0000_0000;
        return v[47:0];
    endfunction

    function automatic stats_t update_stats(logic signed [31:0] x, y, z, t);
        stats_t r;
        logic signed [63:0] v, d;
        logic [127:0] mag, s, q, inc;
        logic [64:0] acc;
        bit hit;
        hit = x >= box_q[REG_X_LO] && x <= box_q[REG_X_HI] &&
              y >= box_q[REG_Y_LO] && y <= box_q[REG_Y_HI] &&
              z >= box_q[REG_Z_LO] && z <= box_q[REG_Z_HI] &&
              n_cnt != bfrs_pkg::COUNT_LIMIT;
        if (hit) begin
            n_cnt = n_cnt + 1;
            t_sum = t_sum + {{32{t[31]}}, t};
            if (t < t_min) t_min = t;
            if (t > t_max) t_max = t;
            v = 64'(t) <<< bfrs_pkg::FRAC_W;
            if (n_cnt == 1) begin
                mean_q = sat48(v);
                sqdev_q = '0;
            end else begin
                d = v - 64'(mean_q);
                mag = (d < 0) ? 128'(-d) : 128'(d);
                s = (mag * mag) >> bfrs_pkg::FRAC_W;
                q = (s + 128'(n_cnt) - 1) / 128'(n_cnt);
                inc = s - q;
                acc = {1'b0, sqdev_q} + {1'b0, inc[63:0]};
                sqdev_q = (inc[127:64] != 0 || acc[64]) ? '1 : acc[63:0];
                mag = mag / 128'(n_cnt);
                mean_q = sat48((d < 0) ? 64'(mean_q) - 64'(mag) : 64'(mean_q) + 64'(mag));
            end
        end
        r.in_region = hit;
        r.count     = n_cnt;
        r.tsum      = t_sum;
        r.tmin      = t_min;
        r.tmax      = t_max;
        r.mean      = mean_q;
        r.sqdev     = sqdev_q;
        r.variance  = (n_cnt == 0) ? '0 : sqdev_q / 64'(n_cnt);
        return r;
    endfunction

    task automatic reg_write(int idx, logic [31:0] val);
        psel <= 1; pwrite <= 1; paddr <= 5'(idx * 4); pwdata <= val; penable <= 0;
        @(posedge aclk);
        penable <= 1;
        do @(posedge aclk); while (!pready);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge aclk);
        if (idx < bfrs_pkg::NREG) box_q[idx] = val;
    endtask

    task automatic set_box(logic [31:0] xl, xh, yl, yh, zl, zh);
        reg_write(REG_X_LO, xl); reg_write(REG_X_HI, xh);
        reg_write(REG_Y_LO, yl); reg_write(REG_Y_HI, yh);
        reg_write(REG_Z_LO, zl); reg_write(REG_Z_HI, zh);
    endtask

    // offers one word, returns once it is taken; typed rows replace the prediction
    task automatic send_word(logic signed [31:0] x, y, z, t, bit typed = 0, stats_t res = '0);
        stats_t p;
        if (burst_left == 0) begin
            int gap = $urandom_range(0, max_gap);
            if (gap != 0) begin
                s_tvalid <= 0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid <= 1;
        s_tdata  <= {t, z, y, x};
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        words_in++;
        p = update_stats(x, y, z, t);
        stats_due.push_back(typed ? res : p);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        burst_left = 0;
        while (stats_due.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    function automatic logic signed [31:0] pick_axis(logic signed [31:0] lo, hi);
        longint span;
        if (lo > hi || $urandom_range(0, 9) < 3) return $urandom;
        case ($urandom_range(0, 7))
            0: return lo;
            1: return hi;
            default: begin
                span = longint'(hi) - longint'(lo) + 1;
                return 32'(longint'(lo) + ({$urandom, $urandom} % span));
            end
        endcase
    endfunction

    task automatic random_phase(int items, bit wide_time, bit do_hold);
        logic signed [31:0] t;
        for (int i = 0; i < items; i++) begin
            if (do_hold && i == items / 3) hold_go = 1;
            if (i == items / 2) max_gap = 0;
            if (i == 3 * items / 4) max_gap = 6;
            t = wide_time ? $urandom : 32'($signed($urandom_range(0, 65535)) - 32768);
            send_word(pick_axis(box_q[REG_X_LO], box_q[REG_X_HI]),
                      pick_axis(box_q[REG_Y_LO], box_q[REG_Y_HI]),
                      pick_axis(box_q[REG_Z_LO], box_q[REG_Z_HI]), t);
        end
        drain();
    endtask

    function automatic void cmp(string name, logic [63:0] exp_v, act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            stats_t e;
            words_out++;
            if (stats_due.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
            end else begin
                e = stats_due.pop_front();
                if (e.in_region) hits++;
                cmp("in_region", e.in_region, m_tuser);
                cmp("match_count", e.count, m_tdata[31:0]);
                cmp("time_sum", e.tsum, m_tdata[95:32]);
                cmp("time_min", e.tmin, m_tdata[127:96]);
                cmp("time_max", e.tmax, m_tdata[159:128]);
                cmp("mean_fixed", e.mean, m_tdata[207:160]);
                cmp("sq_dev_sum", e.sqdev, m_tdata[271:208]);
                cmp("variance_fixed", e.variance, m_tdata[335:272]);
            end
        end
    end

    // receiver: rotating stall pattern plus a long hold-off on each request
    initial begin
        int cyc = 0;
        forever begin
            @(posedge aclk);
            if (hold_go) begin
                hold_go = 0;
                m_tready <= 0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            cyc++;
            case ((cyc / 256) % 3)
                0: m_tready <= 1;
                1: m_tready <= (cyc % 7) < 4;
                default: m_tready <= $urandom_range(0, 1);
            endcase
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cnt <= 0;
        else if (aresetn) idle_cnt <= idle_cnt + 1;
        if (idle_cnt == IDLE_LIMIT) begin
            $display("box_filtered_running_stats_top_test NOT OK");
            $finish;
        end
    end

    initial begin
        row_t rows [$];
        row_t r;
        for (int i = 0; i < bfrs_pkg::NREG; i++) box_q[i] = '0;
        n_cnt = '0; t_sum = '0; t_min = bfrs_pkg::TIME_MAX_V; t_max = bfrs_pkg::TIME_MIN_V;
        mean_q = '0; sqdev_q = '0;

        // box is the origin after reset
        r = '{x: 1, y: 0, z: 0, t: 9, typed: 1,
              res: '{0, 0, 0, bfrs_pkg::TIME_MAX_V, bfrs_pkg::TIME_MIN_V, 0, 0, 0}};
        rows.push_back(r);
        r = '{x: 0, y: 0, z: 0, t: 5, typed: 1, res: '{1, 1, 5, 5, 5, 48'h5_0000, 0, 0}};
        rows.push_back(r);
        r.typed = 0;
        r.t = 7;  rows.push_back(r);
        r.t = -3; rows.push_back(r);
        r.x = 32'sh7FFF_FFFF; r.t = 32'sh7FFF_FFFF; rows.push_back(r);
        r.x = 32'sh8000_0000; r.t = 32'sh8000_0000; rows.push_back(r);
        r.x = 0; r.y = -1; rows.push_back(r);
        r.y = 32'sh7FFF_FFFF; rows.push_back(r);
        r.y = 0; r.z = 1; rows.push_back(r);
        r.z = 32'sh8000_0000; rows.push_back(r);
        r.z = 0; r.t = 0; rows.push_back(r);
        r.t = -1; rows.push_back(r);
        r.t = 100; rows.push_back(r);

        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        foreach (rows[i]) send_word(rows[i].x, rows[i].y, rows[i].z, rows[i].t,
                                    rows[i].typed, rows[i].res);
        drain();

        // index past the box registers is ignored
        reg_write(bfrs_pkg::NREG, 32'h1234_5678);
        reg_write(bfrs_pkg::NREG + 1, '1);
        set_box(-1000, 1000, -1000, 1000, -1000, 1000);
        random_phase(250, 0, 1);
        set_box(500, 499, -1000, 1000, -1000, 1000);
        random_phase(120, 0, 0);
        set_box($urandom, $urandom, -32'sd50000, 32'sd50000, 32'sh8000_0000, 32'sh7FFF_FFFF);
        if ($signed(box_q[REG_X_LO]) > $signed(box_q[REG_X_HI]))
            set_box(box_q[REG_X_HI], box_q[REG_X_LO], box_q[REG_Y_LO], box_q[REG_Y_HI],
                    box_q[REG_Z_LO], box_q[REG_Z_HI]);
        random_phase(250, 0, 0);
        set_box(7, 7, -7, -7, 0, 0);
        random_phase(120, 0, 0);
        set_box(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                32'sh8000_0000, 32'sh7FFF_FFFF);
        random_phase(300, 0, 1);
        random_phase(200, 1, 0);
        repeat (50) @(posedge aclk);

        $display("Sent %0d samples over six box settings, %0d counted, %0d results checked.",
                 words_in, hits, words_out);
        if (errors == 0 && stats_due.size() == 0) begin
            $display("box_filtered_running_stats_top_test OK");
        end else begin
            $display("box_filtered_running_stats_top_test NOT OK");
        end
        $finish;
    end
endmodule
